/* design/tmis_pkg.sv */
// Package for the tape-machine interpreter step unit.
// Holds sizes, command/opcode/status codes, FSM states and memory request types.
// No dependencies.
package tmis_pkg;

    localparam int PROG_DEPTH = 4096;
    localparam int JUMP_DEPTH = 4096;
    localparam int TAPE_DEPTH = 32768;

    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int JUMP_AW = $clog2(JUMP_DEPTH);
    localparam int TAPE_AW = $clog2(TAPE_DEPTH);

    localparam int WORD_W = 16;
    localparam int TGT_W  = 12;
    localparam int CELL_W = 8;
    localparam int PC_W   = 13;
    localparam int LIM_W  = 12;

    localparam logic [WORD_W-1:0] JUMP_BASE = 16'd8;

    typedef enum logic [1:0] {
        CMD_PROG = 2'd0,
        CMD_JUMP = 2'd1,
        CMD_STEP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        OP_RIGHT = 3'd0,
        OP_LEFT  = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_PUT   = 3'd4,
        OP_GET   = 3'd5,
        OP_SKIP  = 3'd6,
        OP_NOP   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_PAST = 2'd1,
        ST_BADJ = 2'd2
    } run_status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_JUMP
    } state_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [PROG_AW-1:0] addr;
        logic [WORD_W-1:0]  wdata;
    } prog_req_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [JUMP_AW-1:0] addr;
        logic [TGT_W-1:0]   wdata;
    } jump_req_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [TAPE_AW-1:0] addr;
        logic [CELL_W-1:0]  wdata;
    } tape_req_t;

endpackage

/* design/tape_machine_interpreter_step_unit.sv */
// Top level of the tape-machine interpreter step unit.
// Depends on tmis_pkg, tmis_core and tmis_ram (program, jump table, tape).
//
// Usage:
//   A request (cmd, addr, word, in_char) is taken at a clock edge where start
//   is high and busy is low. cmd 0 loads a program word, cmd 1 loads a jump
//   target, cmd 2 executes one instruction at the program counter.
//   Every request yields one result (out_valid, out_char, status, pc_now),
//   shown for exactly one cycle with done high; the receiver cannot stall.
//   Loads and steps that execute nothing report in the cycle after
//   acceptance; an executed instruction reports from the S_EXEC state
//   (program word and cell read), and a taken jump whose index lies in the
//   table also passes S_JUMP (jump table read) before it reports.
//   busy stays high until the result cycle, so a new request can be taken in
//   the same cycle as the previous result.
//   The register last_address is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
//   After reset the tape memory is cleared one cell per cycle: busy stays high
//   until all 32768 cells are zero; configuration writes are taken meanwhile.
module tape_machine_interpreter_step_unit
    import tmis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [11:0]        addr,
    input  logic [WORD_W-1:0]  word,
    input  logic [CELL_W-1:0]  in_char,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIM_W-1:0]   cfg_data,
    output logic               done,
    output logic               out_valid,
    output logic [CELL_W-1:0]  out_char,
    output logic [1:0]         status,
    output logic [PC_W-1:0]    pc_now
);

    prog_req_t         prog_req;
    jump_req_t         jump_req;
    tape_req_t         tape_req;
    logic [WORD_W-1:0] prog_rdata;
    logic [TGT_W-1:0]  jump_rdata;
    logic [CELL_W-1:0] tape_rdata;

    tmis_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .addr       (addr),
        .word       (word),
        .in_char    (in_char),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .out_valid  (out_valid),
        .out_char   (out_char),
        .status     (status),
        .pc_now     (pc_now),
        .prog_req   (prog_req),
        .prog_rdata (prog_rdata),
        .jump_req   (jump_req),
        .jump_rdata (jump_rdata),
        .tape_req   (tape_req),
        .tape_rdata (tape_rdata)
    );

    tmis_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_req.we),
        .re    (prog_req.re),
        .addr  (prog_req.addr),
        .wdata (prog_req.wdata),
        .rdata (prog_rdata)
    );

    tmis_ram #(
        .WIDTH (TGT_W),
        .DEPTH (JUMP_DEPTH)
    ) u_jump_ram (
        .clk   (clk),
        .we    (jump_req.we),
        .re    (jump_req.re),
        .addr  (jump_req.addr),
        .wdata (jump_req.wdata),
        .rdata (jump_rdata)
    );

    tmis_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_req.we),
        .re    (tape_req.re),
        .addr  (tape_req.addr),
        .wdata (tape_req.wdata),
        .rdata (tape_rdata)
    );

endmodule

/* design/tmis_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module tmis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tmis_core.sv */
// Control and datapath of the interpreter: command decode, instruction execute,
// tape read-modify-write, jump resolution and tape clearing sweep.
// Depends on tmis_pkg; drives the three memories through request structs.
module tmis_core
    import tmis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [11:0]        addr,
    input  logic [WORD_W-1:0]  word,
    input  logic [CELL_W-1:0]  in_char,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIM_W-1:0]   cfg_data,
    output logic               done,
    output logic               out_valid,
    output logic [CELL_W-1:0]  out_char,
    output logic [1:0]         status,
    output logic [PC_W-1:0]    pc_now,
    output prog_req_t          prog_req,
    input  logic [WORD_W-1:0]  prog_rdata,
    output jump_req_t          jump_req,
    input  logic [TGT_W-1:0]   jump_rdata,
    output tape_req_t          tape_req,
    input  logic [CELL_W-1:0]  tape_rdata
);

    state_t             state_reg, state_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [TAPE_AW-1:0] dp_reg, dp_next;
    run_status_t        stat_reg, stat_next;
    logic [LIM_W-1:0]   last_reg, last_next;
    logic [TAPE_AW-1:0] clr_reg, clr_next;
    logic               oob_reg, oob_next;
    logic [CELL_W-1:0]  in_char_reg, in_char_next;
    logic               done_reg, done_next;
    logic               oval_reg, oval_next;
    logic [CELL_W-1:0]  ochar_reg, ochar_next;

    logic [WORD_W-1:0]  w;
    logic [CELL_W-1:0]  cur_cell;
    logic [WORD_W-1:0]  idx;
    logic               take;
    logic               upd_pc;
    logic [PC_W-1:0]    pc_new;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign out_valid = oval_reg;
    assign out_char  = ochar_reg;
    assign status    = stat_reg;
    assign pc_now    = pc_reg;

    assign w        = oob_reg ? '0 : prog_rdata;
    assign cur_cell = tape_rdata;
    assign idx      = w - JUMP_BASE;
    assign take     = w[0] ? (cur_cell != '0) : (cur_cell == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= '0;
            dp_reg    <= '0;
            stat_reg  <= ST_RUN;
            last_reg  <= '0;
            clr_reg   <= '0;
            oob_reg   <= 1'b0;
            done_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            dp_reg    <= dp_next;
            stat_reg  <= stat_next;
            last_reg  <= last_next;
            clr_reg   <= clr_next;
            oob_reg   <= oob_next;
            done_reg  <= done_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_char_reg <= in_char_next;
        ochar_reg   <= ochar_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        dp_next      = dp_reg;
        stat_next    = stat_reg;
        last_next    = last_reg;
        clr_next     = clr_reg;
        oob_next     = oob_reg;
        in_char_next = in_char_reg;
        done_next    = 1'b0;
        oval_next    = 1'b0;
        ochar_next   = '0;
        prog_req     = '0;
        jump_req     = '0;
        tape_req     = '0;
        upd_pc       = 1'b0;
        pc_new       = pc_reg + PC_W'(1);

        if (cfg_valid)
        begin
            last_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                tape_req.we    = 1'b1;
                tape_req.addr  = clr_reg;
                tape_req.wdata = '0;
                clr_next       = clr_reg + TAPE_AW'(1);
                if (clr_reg == TAPE_AW'(TAPE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_PROG:
                        begin
                            if (17'(addr) < 17'(PROG_DEPTH))
                            begin
                                prog_req.we    = 1'b1;
                                prog_req.addr  = PROG_AW'(addr);
                                prog_req.wdata = word;
                            end
                        end
                        CMD_JUMP:
                        begin
                            if (17'(addr) < 17'(JUMP_DEPTH))
                            begin
                                jump_req.we    = 1'b1;
                                jump_req.addr  = JUMP_AW'(addr);
                                jump_req.wdata = word[TGT_W-1:0];
                            end
                        end
                        CMD_STEP:
                        begin
                            if (stat_reg == ST_RUN)
                            begin
                                if (pc_reg > PC_W'(last_reg))
                                begin
                                    stat_next = ST_PAST;
                                end
                                else
                                begin
                                    done_next     = 1'b0;
                                    prog_req.re   = 1'b1;
                                    prog_req.addr = PROG_AW'(pc_reg);
                                    tape_req.re   = 1'b1;
                                    tape_req.addr = dp_reg;
                                    oob_next      = (17'(pc_reg) >= 17'(PROG_DEPTH));
                                    in_char_next  = in_char;
                                    state_next    = S_EXEC;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                upd_pc     = 1'b1;
                if (w[WORD_W-1:3] == '0)
                begin
                    tape_req.addr = dp_reg;
                    unique case (op_t'(w[2:0]))
                        OP_RIGHT:
                        begin
                            dp_next = (dp_reg == TAPE_AW'(TAPE_DEPTH - 1)) ? '0
                                                                          : dp_reg + TAPE_AW'(1);
                        end
                        OP_LEFT:
                        begin
                            dp_next = (dp_reg == '0) ? TAPE_AW'(TAPE_DEPTH - 1)
                                                     : dp_reg - TAPE_AW'(1);
                        end
                        OP_INC:
                        begin
                            tape_req.we    = 1'b1;
                            tape_req.wdata = cur_cell + CELL_W'(1);
                        end
                        OP_DEC:
                        begin
                            tape_req.we    = 1'b1;
                            tape_req.wdata = cur_cell - CELL_W'(1);
                        end
                        OP_PUT:
                        begin
                            oval_next  = 1'b1;
                            ochar_next = cur_cell;
                        end
                        OP_GET:
                        begin
                            tape_req.we    = 1'b1;
                            tape_req.wdata = in_char_reg;
                        end
                        OP_SKIP:
                        begin
                            pc_new = pc_reg + PC_W'(2);
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (take)
                begin
                    upd_pc = 1'b0;
                    if (17'(idx) >= 17'(JUMP_DEPTH))
                    begin
                        stat_next = ST_BADJ;
                    end
                    else
                    begin
                        jump_req.re   = 1'b1;
                        jump_req.addr = JUMP_AW'(idx);
                        done_next     = 1'b0;
                        state_next    = S_JUMP;
                    end
                end
            end
            S_JUMP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (jump_rdata >= last_reg)
                begin
                    stat_next = ST_BADJ;
                end
                else
                begin
                    upd_pc = 1'b1;
                    pc_new = PC_W'(jump_rdata) + PC_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (upd_pc)
        begin
            pc_next = pc_new;
            if (pc_new > PC_W'(last_reg))
            begin
                stat_next = ST_PAST;
            end
        end
    end

endmodule
